@@ rtl/mavg_pkg.sv @@
// ----------------------------------------------------------------------------
// mavg_pkg: shared constants for the moving-average H-bridge PWM block
// Full-scale duty, register reset values, register indexes and width helpers.
// ----------------------------------------------------------------------------
package mavg_pkg;

    localparam int unsigned SAMPLE_W       = 12;
    localparam int unsigned DUTY_W         = 12;
    localparam int unsigned CFG_IDX_W      = 2;
    localparam int unsigned CFG_DATA_W     = 12;
    localparam int unsigned WINDOW_DEFAULT = 100;

    localparam logic [DUTY_W-1:0] FULL_DUTY       = 12'd3600;
    localparam logic [DUTY_W-1:0] UPPER_BAND_RST  = 12'd3500;
    localparam logic [DUTY_W-1:0] LOWER_BAND_RST  = 12'd100;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_BAND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER_BAND = 2'd1;

    // bits for a sum of window samples of full scale
    function automatic int unsigned sum_width(input int unsigned window);
        return $clog2(4095 * window + 1);
    endfunction

    // bits for a ring index
    function automatic int unsigned ptr_width(input int unsigned window);
        return (window > 1) ? $clog2(window) : 1;
    endfunction

endpackage

@@ rtl/mavg_ring.sv @@
// ----------------------------------------------------------------------------
// mavg_ring: sample ring and running sum
// Input stage reads the oldest ring entry; the sum stage swaps it for the new
// sample and keeps the running sum of the window.
// ----------------------------------------------------------------------------
module mavg_ring
    import mavg_pkg::*;
#(
    parameter int unsigned WINDOW = WINDOW_DEFAULT,
    parameter int unsigned SUM_W  = sum_width(WINDOW)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [SAMPLE_W-1:0] setpoint_sample,
    input  logic                gen_mode,
    output logic                sum_valid,
    input  logic                sum_stall,
    output logic [SUM_W-1:0]    sum,
    output logic                sum_pin
);

    localparam int unsigned PTR_W = ptr_width(WINDOW);
    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(WINDOW - 1);
    localparam logic [PTR_W-1:0] PTR_FIRST = (WINDOW > 1) ? PTR_W'(1) : PTR_W'(0);

    logic [SAMPLE_W-1:0] ring_mem [WINDOW];
    logic [WINDOW-1:0]   written_reg;

    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_next;

    logic                s1_valid_reg;
    logic [SAMPLE_W-1:0] s1_sample_reg;
    logic                s1_pin_reg;
    logic [PTR_W-1:0]    s1_addr_reg;
    logic [SAMPLE_W-1:0] s1_rd_data_reg;
    logic                s1_written_reg;
    logic                s1_bypass_reg;
    logic [SAMPLE_W-1:0] s1_bypass_data_reg;
    logic [SAMPLE_W-1:0] s1_old;

    logic                s2_valid_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    sum_next;
    logic                s2_pin_reg;

    logic                s1_stall;
    logic                s2_stall;
    logic                accept;
    logic                s1_advance;

    assign s2_stall   = s2_valid_reg & sum_stall;
    assign s1_stall   = s1_valid_reg & s2_stall;
    assign in_stall   = s1_stall;
    assign accept     = in_valid & ~s1_stall;
    assign s1_advance = s1_valid_reg & ~s2_stall;

    assign rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);

    // never-written entries read as zero; a write to the entry being read wins
    always_comb
    begin
        if (s1_bypass_reg)
        begin
            s1_old = s1_bypass_data_reg;
        end
        else if (s1_written_reg)
        begin
            s1_old = s1_rd_data_reg;
        end
        else
        begin
            s1_old = '0;
        end
    end

    assign sum_next = sum_reg + SUM_W'(s1_sample_reg) - SUM_W'(s1_old);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg   <= PTR_FIRST;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            written_reg  <= '0;
            sum_reg      <= '0;
        end
        else
        begin
            if (!s1_stall)
            begin
                s1_valid_reg <= in_valid;
            end
            if (!s2_stall)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (accept)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            if (s1_advance)
            begin
                written_reg[s1_addr_reg] <= 1'b1;
                sum_reg                  <= sum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            ring_mem[s1_addr_reg] <= s1_sample_reg;
            s2_pin_reg            <= s1_pin_reg;
        end
        if (accept)
        begin
            s1_sample_reg      <= setpoint_sample;
            s1_pin_reg         <= gen_mode;
            s1_addr_reg        <= rd_ptr_reg;
            s1_rd_data_reg     <= ring_mem[rd_ptr_reg];
            s1_written_reg     <= written_reg[rd_ptr_reg];
            s1_bypass_reg      <= s1_advance && (s1_addr_reg == rd_ptr_reg);
            s1_bypass_data_reg <= s1_sample_reg;
        end
    end

    assign sum_valid = s2_valid_reg;
    assign sum       = sum_reg;
    assign sum_pin   = s2_pin_reg;

endmodule

@@ rtl/mavg_scale.sv @@
// ----------------------------------------------------------------------------
// mavg_scale: window sum to duty
// Exact floor(sum*3600/(4096*WINDOW)) by one reciprocal multiply and shift.
// ----------------------------------------------------------------------------
module mavg_scale
    import mavg_pkg::*;
#(
    parameter int unsigned WINDOW = WINDOW_DEFAULT,
    parameter int unsigned SUM_W  = sum_width(WINDOW)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sum_valid,
    output logic              sum_stall,
    input  logic [SUM_W-1:0]  sum,
    input  logic              sum_pin,
    output logic              duty_valid,
    input  logic              duty_stall,
    output logic [DUTY_W-1:0] duty,
    output logic              duty_pin
);

    // 3600/4096 reduces to 225/256; the shift makes the rounded-up
    // reciprocal exact for every sum below 2^SUM_W
    localparam logic [63:0] DEN   = 64'(256 * WINDOW);
    localparam int unsigned SHIFT = SUM_W + $clog2(DEN);
    localparam logic [63:0] MULT  = ((64'd225 << SHIFT) + DEN - 64'd1) / DEN;
    localparam int unsigned KW    = $clog2(MULT + 64'd1);
    localparam int unsigned PW    = SUM_W + KW;

    logic [PW-1:0]     product;
    logic [PW-1:0]     shifted;
    logic              valid_reg;
    logic [DUTY_W-1:0] duty_reg;
    logic              pin_reg;
    logic              stall;

    assign product = PW'(sum) * PW'(MULT[KW-1:0]);
    assign shifted = product >> SHIFT;

    assign stall     = valid_reg & duty_stall;
    assign sum_stall = stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!stall)
        begin
            valid_reg <= sum_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            duty_reg <= shifted[DUTY_W-1:0];
            pin_reg  <= sum_pin;
        end
    end

    assign duty_valid = valid_reg;
    assign duty       = duty_reg;
    assign duty_pin   = pin_reg;

endmodule

@@ rtl/mavg_drive.sv @@
// ----------------------------------------------------------------------------
// mavg_drive: dead bands, inversion, direction and compare outputs
// Holds the bridge direction and the last inverted duty; output register.
// ----------------------------------------------------------------------------
module mavg_drive
    import mavg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [DUTY_W-1:0] upper_band,
    input  logic [DUTY_W-1:0] lower_band,
    input  logic              duty_valid,
    output logic              duty_stall,
    input  logic [DUTY_W-1:0] duty,
    input  logic              duty_pin,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [DUTY_W-1:0] compare_a,
    output logic [DUTY_W-1:0] compare_b,
    output logic              forward_out
);

    logic              valid_reg;
    logic              stall;
    logic              advance;
    logic [DUTY_W-1:0] snapped;
    logic [DUTY_W-1:0] banded;
    logic [DUTY_W-1:0] inv_duty;
    logic              forward_next;
    logic              forward_reg;
    logic [DUTY_W-1:0] last_inv_reg;
    logic [DUTY_W-1:0] compare_a_reg;
    logic [DUTY_W-1:0] compare_b_reg;

    // upper band first, lower band on its result
    assign snapped  = (duty > upper_band) ? FULL_DUTY : duty;
    assign banded   = (snapped < lower_band) ? '0 : snapped;
    assign inv_duty = FULL_DUTY - banded;

    // re-sample the direction only while the bridge is stopped
    assign forward_next = (last_inv_reg == FULL_DUTY) ? ~duty_pin : forward_reg;

    assign stall      = valid_reg & out_stall;
    assign duty_stall = stall;
    assign advance    = duty_valid & ~stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            forward_reg  <= 1'b1;
            last_inv_reg <= FULL_DUTY;
        end
        else
        begin
            if (!stall)
            begin
                valid_reg <= duty_valid;
            end
            if (advance)
            begin
                forward_reg  <= forward_next;
                last_inv_reg <= inv_duty;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            compare_a_reg <= forward_next ? inv_duty : FULL_DUTY;
            compare_b_reg <= forward_next ? FULL_DUTY : inv_duty;
        end
    end

    assign out_valid   = valid_reg;
    assign compare_a   = compare_a_reg;
    assign compare_b   = compare_b_reg;
    assign forward_out = forward_reg;

endmodule

@@ rtl/moving_average_hbridge_pwm.sv @@
// ----------------------------------------------------------------------------
// moving_average_hbridge_pwm: setpoint moving average to H-bridge compare pair
// Averages the last WINDOW setpoint samples and drives two PWM compare values.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one setpoint sample and the
//   generator-mode level per transfer. Output channel (out_valid / out_stall)
//   returns compare_a, compare_b and forward_out, one result per sample.
//   Configuration channel (cfg_valid / cfg_ready, cfg_index, cfg_data) writes
//   the upper (index 0) and lower (index 1) dead bands; other indexes are
//   dropped. cfg_ready is always high; write only while the block is idle.
//   Pipeline: a result passes the four register stages in order: ring read,
//   sum update, scaling multiply, and dead band with the output register.
//   Throughput: one sample per cycle without stalls; each stage holds one item.
//   When the receiver stalls, the output register holds its result and the
//   stages behind it keep filling; in_stall rises only once every stage is
//   full. Reset empties the pipeline, clears the ring and sum, sets the
//   direction to forward with the bridge stopped, and loads the default bands.
// ----------------------------------------------------------------------------
module moving_average_hbridge_pwm
    import mavg_pkg::*;
#(
    parameter int unsigned WINDOW = WINDOW_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [SAMPLE_W-1:0]   setpoint_sample,
    input  logic                  gen_mode,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [DUTY_W-1:0]     compare_a,
    output logic [DUTY_W-1:0]     compare_b,
    output logic                  forward_out,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int unsigned SUM_W = sum_width(WINDOW);

    logic [DUTY_W-1:0] upper_band_reg;
    logic [DUTY_W-1:0] lower_band_reg;

    logic              sum_valid;
    logic              sum_stall;
    logic [SUM_W-1:0]  sum;
    logic              sum_pin;
    logic              duty_valid;
    logic              duty_stall;
    logic [DUTY_W-1:0] duty;
    logic              duty_pin;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_band_reg <= UPPER_BAND_RST;
            lower_band_reg <= LOWER_BAND_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_UPPER_BAND: upper_band_reg <= DUTY_W'(cfg_data);
                REG_LOWER_BAND: lower_band_reg <= DUTY_W'(cfg_data);
                default:        ;
            endcase
        end
    end

    mavg_ring #(
        .WINDOW (WINDOW),
        .SUM_W  (SUM_W)
    ) u_ring (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .setpoint_sample (setpoint_sample),
        .gen_mode        (gen_mode),
        .sum_valid       (sum_valid),
        .sum_stall       (sum_stall),
        .sum             (sum),
        .sum_pin         (sum_pin)
    );

    mavg_scale #(
        .WINDOW (WINDOW),
        .SUM_W  (SUM_W)
    ) u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .sum_valid  (sum_valid),
        .sum_stall  (sum_stall),
        .sum        (sum),
        .sum_pin    (sum_pin),
        .duty_valid (duty_valid),
        .duty_stall (duty_stall),
        .duty       (duty),
        .duty_pin   (duty_pin)
    );

    mavg_drive u_drive (
        .clk         (clk),
        .rst_n       (rst_n),
        .upper_band  (upper_band_reg),
        .lower_band  (lower_band_reg),
        .duty_valid  (duty_valid),
        .duty_stall  (duty_stall),
        .duty        (duty),
        .duty_pin    (duty_pin),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .compare_a   (compare_a),
        .compare_b   (compare_b),
        .forward_out (forward_out)
    );

endmodule

@@ sim/tb_moving_average_hbridge_pwm.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_moving_average_hbridge_pwm: self-checking bench for the setpoint filter
// Drives setpoint samples and the generator-mode level through the valid/stall
// channel, with dead-band writes between phases. A local model of the ring,
// running sum, dead bands and direction latch predicts every compare pair. A
// short directed table comes first. Random plateaus of samples follow, under
// several band settings and idle/stall patterns.
// ----------------------------------------------------------------------------
module tb_moving_average_hbridge_pwm;
    import mavg_pkg::*;

    localparam int unsigned WIN          = WINDOW_DEFAULT;
    localparam int unsigned SUM_W        = $clog2(4095 * WIN + 1);
    localparam int unsigned ADC_SPAN     = 4096;
    localparam int unsigned DRAIN_CYCLES = 12;

    // indexes that decode to no register
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef struct packed {
        logic [DUTY_W-1:0] compare_a;
        logic [DUTY_W-1:0] compare_b;
        logic              forward_out;
    } bridge_cmd_t;

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic                  pin;
        logic                  typed;
        bridge_cmd_t           cmd;
    } plan_row_t;

    typedef enum logic [1:0] {BANDS_FIXED, BANDS_ORDERED, BANDS_ANY} band_mode_t;

    typedef struct packed {
        band_mode_t            band_mode;
        logic [CFG_DATA_W-1:0] upper;
        logic [CFG_DATA_W-1:0] lower;
        logic [6:0]            send_pct;
        logic [6:0]            stall_pct;
        logic [10:0]           items;
        logic                  hold_off;
    } phase_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [SAMPLE_W-1:0]   setpoint_sample = '0;
    logic                  gen_mode = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [DUTY_W-1:0]     compare_a;
    logic [DUTY_W-1:0]     compare_b;
    logic                  forward_out;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // local copy of the filter state
    logic [SAMPLE_W-1:0]   ring_mdl [WIN];
    int unsigned           ring_ptr_mdl;
    logic [SUM_W-1:0]      sum_mdl;
    logic                  fwd_mdl;
    logic [DUTY_W-1:0]     last_inv_mdl;
    logic [CFG_DATA_W-1:0] upper_mdl;
    logic [CFG_DATA_W-1:0] lower_mdl;

    bridge_cmd_t bridge_q [$];

    int unsigned send_gap_pct = 0;
    int unsigned stall_pct    = 0;
    int unsigned n_errors     = 0;
    int unsigned n_samples    = 0;
    int unsigned n_results    = 0;
    int unsigned n_writes     = 0;
    int unsigned n_dir_flips  = 0;

    localparam plan_row_t DIRECTED_PLAN [27] = '{
        '{ROW_SAMPLE, '0, 12'd0,    1'b0, 1'b1, '{FULL_DUTY, FULL_DUTY, 1'b1}},
        '{ROW_SAMPLE, '0, 12'd4095, 1'b1, 1'b1, '{FULL_DUTY, FULL_DUTY, 1'b0}},
        '{ROW_WRITE,  REG_UPPER_BAND, 12'd0, 1'b0, 1'b0, '0},
        '{ROW_WRITE,  REG_LOWER_BAND, 12'd0, 1'b0, 1'b0, '0},
        '{ROW_SAMPLE, '0, 12'd4095, 1'b0, 1'b1, '{12'd0, FULL_DUTY, 1'b1}},
        // bridge running: pin change must not flip the direction
        '{ROW_SAMPLE, '0, 12'd0,    1'b1, 1'b1, '{12'd0, FULL_DUTY, 1'b1}},
        // lower band above full scale turns a snapped full duty into zero
        '{ROW_WRITE,  REG_LOWER_BAND, 12'd4095, 1'b0, 1'b0, '0},
        '{ROW_SAMPLE, '0, 12'd4095, 1'b1, 1'b1, '{FULL_DUTY, FULL_DUTY, 1'b1}},
        '{ROW_SAMPLE, '0, 12'd0,    1'b1, 1'b1, '{FULL_DUTY, FULL_DUTY, 1'b0}},
        '{ROW_WRITE,  REG_SPARE_2, 12'd0, 1'b0, 1'b0, '0},
        '{ROW_WRITE,  REG_SPARE_3, 12'd0, 1'b0, 1'b0, '0},
        '{ROW_SAMPLE, '0, 12'd4095, 1'b0, 1'b1, '{FULL_DUTY, FULL_DUTY, 1'b1}},
        '{ROW_WRITE,  REG_UPPER_BAND, 12'd3600, 1'b0, 1'b0, '0},
        '{ROW_WRITE,  REG_LOWER_BAND, 12'd0,    1'b0, 1'b0, '0},
        '{ROW_SAMPLE, '0, 12'd4095, 1'b1, 1'b0, '0},
        '{ROW_SAMPLE, '0, 12'd4095, 1'b0, 1'b0, '0},
        '{ROW_SAMPLE, '0, 12'd2048, 1'b1, 1'b0, '0},
        '{ROW_WRITE,  REG_UPPER_BAND, 12'd4095, 1'b0, 1'b0, '0},
        '{ROW_WRITE,  REG_LOWER_BAND, 12'd3600, 1'b0, 1'b0, '0},
        '{ROW_SAMPLE, '0, 12'd4095, 1'b0, 1'b0, '0},
        '{ROW_SAMPLE, '0, 12'd0,    1'b1, 1'b0, '0},
        '{ROW_WRITE,  REG_UPPER_BAND, 12'd3500, 1'b0, 1'b0, '0},
        '{ROW_WRITE,  REG_LOWER_BAND, 12'd100,  1'b0, 1'b0, '0},
        '{ROW_SAMPLE, '0, 12'hAAA,  1'b0, 1'b0, '0},
        '{ROW_SAMPLE, '0, 12'h555,  1'b1, 1'b0, '0},
        '{ROW_SAMPLE, '0, 12'd4095, 1'b0, 1'b0, '0},
        '{ROW_SAMPLE, '0, 12'd0,    1'b0, 1'b0, '0}
    };

    localparam phase_t PHASE_PLAN [8] = '{
        '{BANDS_FIXED,   12'd3500, 12'd100,  7'd0,  7'd0,  11'd200, 1'b0},
        '{BANDS_FIXED,   12'd3600, 12'd0,    7'd81, 7'd0,  11'd200, 1'b0},
        '{BANDS_FIXED,   12'd0,    12'd0,    7'd0,  7'd81, 11'd150, 1'b0},
        '{BANDS_FIXED,   12'd4095, 12'd4095, 7'd29, 7'd29, 11'd150, 1'b1},
        '{BANDS_ORDERED, 12'd0,    12'd0,    7'd81, 7'd0,  11'd200, 1'b0},
        '{BANDS_ANY,     12'd0,    12'd0,    7'd0,  7'd81, 11'd200, 1'b0},
        '{BANDS_FIXED,   12'd3000, 12'd600,  7'd29, 7'd29, 11'd250, 1'b1},
        '{BANDS_ORDERED, 12'd0,    12'd0,    7'd29, 7'd29, 11'd250, 1'b0}
    };

    moving_average_hbridge_pwm #(.WINDOW(WIN)) dut (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void reset_filter_model();
        for (int i = 0; i < WIN; i++)
            ring_mdl[i] = '0;
        ring_ptr_mdl = 0;
        sum_mdl      = '0;
        fwd_mdl      = 1'b1;
        last_inv_mdl = FULL_DUTY;
        upper_mdl    = UPPER_BAND_RST;
        lower_mdl    = LOWER_BAND_RST;
    endfunction

    function automatic bridge_cmd_t predict_bridge(input logic [SAMPLE_W-1:0] smp,
                                                   input logic pin);
        logic [39:0]       scaled;
        logic [DUTY_W-1:0] duty;
        logic [DUTY_W-1:0] inv;
        bridge_cmd_t       cmd;
        // direction may only change while the bridge is stopped
        if (last_inv_mdl == FULL_DUTY)
        begin
            if (fwd_mdl != ~pin)
                n_dir_flips++;
            fwd_mdl = ~pin;
        end
        ring_ptr_mdl = (ring_ptr_mdl == WIN - 1) ? 0 : ring_ptr_mdl + 1;
        sum_mdl = sum_mdl - SUM_W'(ring_mdl[ring_ptr_mdl]) + SUM_W'(smp);
        ring_mdl[ring_ptr_mdl] = smp;
        scaled = (40'(sum_mdl) * 40'(FULL_DUTY)) / 40'(ADC_SPAN * WIN);
        duty = scaled[DUTY_W-1:0];
        if (duty > upper_mdl)
            duty = FULL_DUTY;
        if (duty < lower_mdl)
            duty = '0;
        inv = FULL_DUTY - duty;
        last_inv_mdl = inv;
        cmd.compare_a   = fwd_mdl ? inv : FULL_DUTY;
        cmd.compare_b   = fwd_mdl ? FULL_DUTY : inv;
        cmd.forward_out = fwd_mdl;
        return cmd;
    endfunction

    // drop valid and hold until every expected result has come back
    task automatic settle();
        in_valid <= 1'b0;
        while (bridge_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_band(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] data);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == REG_UPPER_BAND)
            upper_mdl = data;
        else if (idx == REG_LOWER_BAND)
            lower_mdl = data;
        n_writes++;
    endtask

    task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic pin,
                               input logic typed, input bridge_cmd_t typed_cmd);
        bridge_cmd_t cmd;
        while (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid        <= 1'b1;
        setpoint_sample <= smp;
        gen_mode        <= pin;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        cmd = predict_bridge(smp, pin);
        bridge_q.push_back(typed ? typed_cmd : cmd);
        n_samples++;
    endtask

    // a plateau around one level, with noise, outliers and rare pin changes
    task automatic drive_burst(input int unsigned count);
        int   level;
        int   spread;
        int   v;
        logic pin;
        case ($urandom_range(0, 3))
            0: level = 0;
            1: level = 4095;
            default: level = $urandom_range(0, 4095);
        endcase
        spread = ($urandom_range(0, 3) == 0) ? 2048 : $urandom_range(0, 64);
        pin = 1'($urandom_range(0, 1));
        for (int k = 0; k < count; k++)
        begin
            if ($urandom_range(0, 15) == 0)
                pin = ~pin;
            if ($urandom_range(0, 7) == 0)
                v = $urandom_range(0, 4095);
            else
            begin
                v = level + int'($urandom_range(0, 2 * spread)) - spread;
                if (v < 0)
                    v = 0;
                if (v > 4095)
                    v = 4095;
            end
            send_sample(v[SAMPLE_W-1:0], pin, 1'b0, '0);
        end
    endtask

    always @(posedge clk)
        out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);

    always @(posedge clk)
    begin
        bridge_cmd_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            n_results++;
            if (bridge_q.size() == 0)
            begin
                $error("result with nothing expected: a=%0d b=%0d fwd=%0d",
                       compare_a, compare_b, forward_out);
                n_errors++;
            end
            else
            begin
                want = bridge_q.pop_front();
                if (compare_a !== want.compare_a)
                begin
                    $error("compare_a: expected %0d, actual %0d", want.compare_a, compare_a);
                    n_errors++;
                end
                if (compare_b !== want.compare_b)
                begin
                    $error("compare_b: expected %0d, actual %0d", want.compare_b, compare_b);
                    n_errors++;
                end
                if (forward_out !== want.forward_out)
                begin
                    $error("forward_out: expected %0d, actual %0d",
                           want.forward_out, forward_out);
                    n_errors++;
                end
            end
        end
    end

    initial
    begin
        #3_000_000;
        $display("FAIL moving_average_hbridge_pwm");
        $finish;
    end

    initial
    begin
        plan_row_t             row;
        phase_t                ph;
        logic [CFG_DATA_W-1:0] up;
        logic [CFG_DATA_W-1:0] lo;
        int unsigned           left;
        int unsigned           n;
        logic                  quiet;
        logic                  held;

        reset_filter_model();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < $size(DIRECTED_PLAN); i++)
        begin
            row = DIRECTED_PLAN[i];
            if (row.kind == ROW_WRITE)
                write_band(row.idx, row.data);
            else
                send_sample(row.data[SAMPLE_W-1:0], row.pin, row.typed, row.cmd);
        end

        for (int p = 0; p < $size(PHASE_PLAN); p++)
        begin
            ph = PHASE_PLAN[p];
            case (ph.band_mode)
                BANDS_ORDERED:
                begin
                    up = CFG_DATA_W'($urandom_range(0, FULL_DUTY));
                    lo = CFG_DATA_W'($urandom_range(0, up));
                end
                BANDS_ANY:
                begin
                    up = CFG_DATA_W'($urandom_range(0, 4095));
                    lo = CFG_DATA_W'($urandom_range(0, 4095));
                end
                default:
                begin
                    up = ph.upper;
                    lo = ph.lower;
                end
            endcase
            write_band(REG_UPPER_BAND, up);
            write_band(REG_LOWER_BAND, lo);
            held = 1'b0;
            left = 32'(ph.items);
            while (left > 0)
            begin
                quiet = ($urandom_range(0, 3) == 0);
                send_gap_pct = quiet ? 0 : ph.send_pct;
                stall_pct    = quiet ? 0 : ph.stall_pct;
                n = $urandom_range(40, 250);
                if (n > left)
                    n = left;
                drive_burst(n);
                left -= n;
                // hold off the sender once until the pipeline has emptied
                if (ph.hold_off && !held)
                begin
                    settle();
                    held = 1'b1;
                end
            end
        end

        settle();
        $display("Run covered %0d samples in %0d random phases, %0d register writes,",
                 n_samples, $size(PHASE_PLAN), n_writes);
        $display("%0d direction changes and %0d checked results.", n_dir_flips, n_results);
        if (n_errors == 0)
            $display("PASS moving_average_hbridge_pwm");
        else
            $display("FAIL moving_average_hbridge_pwm");
        $finish;
    end

endmodule
